>>> design/npncf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NPN canonical form package
// Shared types, the permutation table and helpers for the input count.
// ----------------------------------------------------------------------------
package npncf_pkg;

    localparam int MAX_INPUTS = 4;
    localparam int NUM_PERMS  = 24;
    localparam int PIDX_W     = 5;

    localparam logic [2:0] RESET_COUNT = 3'd4;

    // Lexicographic permutations of four inputs; bits 2i+1..2i hold the
    // new position of input i.
    localparam logic [7:0] PERM_CODES [NUM_PERMS] = '{
        8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
        8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
        8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
        8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

    function automatic logic [2:0] sat_count(input logic [2:0] raw);
        logic [2:0] n;
        n = raw;
        if (raw == 3'd0) begin
            n = 3'd1;
        end else if (raw > 3'(MAX_INPUTS)) begin
            n = 3'(MAX_INPUTS);
        end
        return n;
    endfunction

    function automatic logic [15:0] full_mask(input logic [2:0] n);
        logic [15:0] m;
        case (n)
            3'd1:    m = 16'h0003;
            3'd2:    m = 16'h000F;
            3'd3:    m = 16'h00FF;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] last_mask(input logic [2:0] n);
        logic [3:0] m;
        case (n)
            3'd1:    m = 4'h1;
            3'd2:    m = 4'h3;
            3'd3:    m = 4'h7;
            default: m = 4'hF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] code_mask(input logic [2:0] n);
        logic [7:0] m;
        case (n)
            3'd1:    m = 8'h03;
            3'd2:    m = 8'h0F;
            3'd3:    m = 8'h3F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // A permutation belongs to the n-input search when every unused input
    // stays in place.
    function automatic logic perm_ok(input logic [7:0] code, input logic [2:0] n);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < MAX_INPUTS; j++) begin
            if (3'(j) >= n && code[2*j +: 2] != 2'(j)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

>>> design/npncf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NPN canonical form controller
// Sequences input acceptance, the transform search and the result hand-off.
// ----------------------------------------------------------------------------
module npncf_ctrl import npncf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (i_sts.last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.publish = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.publish = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/npncf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NPN canonical form datapath
// Holds the input count, walks permutation and mask counters, builds one
// transformed table per cycle during the search and keeps the best candidate and the result.
// ----------------------------------------------------------------------------
module npncf_dp import npncf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_data,
    input  logic [15:0] i_truth_table,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [15:0] o_canonical_table,
    output logic        o_output_negated,
    output logic [3:0]  o_input_negation_mask,
    output logic [7:0]  o_permutation_code
);

    logic [2:0]        r_input_count;
    logic [15:0]       r_table;
    logic [PIDX_W-1:0] r_pidx;
    logic [3:0]        r_mask;
    logic              r_have;
    logic [15:0]       r_best;
    logic              r_best_neg;
    logic [3:0]        r_best_mask;
    logic [7:0]        r_best_code;
    logic              r_out_valid;
    logic [15:0]       r_out_table;
    logic              r_out_neg;
    logic [3:0]        r_out_mask;
    logic [7:0]        r_out_code;

    logic [2:0]  c_n;
    logic [15:0] c_full;
    logic [7:0]  c_code;
    logic        c_perm_ok;
    logic        c_mask_end;
    logic [15:0] c_t;
    logic [15:0] c_t_neg;
    logic        c_take0;
    logic        c_take1;
    logic [15:0] c_best0;

    assign c_n        = sat_count(r_input_count);
    assign c_full     = full_mask(c_n);
    assign c_code     = PERM_CODES[r_pidx];
    assign c_perm_ok  = perm_ok(c_code, c_n);
    assign c_mask_end = !c_perm_ok || (r_mask == last_mask(c_n));

    // For each minterm i, the source value at i XOR mask goes to the result
    // minterm whose bits are placed by the permutation.
    always_comb begin
        logic [3:0] v_ni;
        logic [3:0] v_src;
        c_t = '0;
        for (int i = 0; i < 16; i++) begin
            v_ni = '0;
            for (int j = 0; j < MAX_INPUTS; j++) begin
                if (i[j]) begin
                    v_ni[c_code[2*j +: 2]] = 1'b1;
                end
            end
            v_src = 4'(i) ^ r_mask;
            if (r_table[v_src]) begin
                c_t[v_ni] = 1'b1;
            end
        end
    end

    // The plain output is weighed first, then the complemented one against
    // whatever won the first comparison.
    assign c_t_neg = c_t ^ c_full;
    assign c_take0 = !r_have || (c_t > r_best);
    assign c_best0 = c_take0 ? c_t : r_best;
    assign c_take1 = c_t_neg > c_best0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count <= RESET_COUNT;
        end else if (i_cfg_valid) begin
            r_input_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_table <= i_truth_table & c_full;
            r_pidx  <= '0;
            r_mask  <= '0;
            r_have  <= 1'b0;
        end else if (i_cmd.step) begin
            if (c_mask_end) begin
                r_mask <= '0;
                r_pidx <= r_pidx + 1'b1;
            end else begin
                r_mask <= r_mask + 1'b1;
            end
            if (c_perm_ok) begin
                r_have <= 1'b1;
                if (c_take1) begin
                    r_best      <= c_t_neg;
                    r_best_neg  <= 1'b1;
                    r_best_mask <= r_mask;
                    r_best_code <= c_code & code_mask(c_n);
                end else if (c_take0) begin
                    r_best      <= c_t;
                    r_best_neg  <= 1'b0;
                    r_best_mask <= r_mask;
                    r_best_code <= c_code & code_mask(c_n);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_table <= r_best;
            r_out_neg   <= r_best_neg;
            r_out_mask  <= r_best_mask;
            r_out_code  <= r_best_code;
        end
    end

    assign o_sts.last     = c_mask_end && (r_pidx == PIDX_W'(NUM_PERMS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_canonical_table     = r_out_table;
    assign o_output_negated      = r_out_neg;
    assign o_input_negation_mask = r_out_mask;
    assign o_permutation_code    = r_out_code;

endmodule

>>> design/npn_canonical_form_top.sv
`timescale 1ns / 1ps
// Operation: an accepted beat is loaded, then the search takes one step per visited
// permutation and mask pair (24 x 16 at four inputs) and one step per permutation
// outside a smaller input count, then the best candidate is loaded into the result.
// No new beat is taken while a search runs; a new beat is taken once the result
// moves to the output register, where it may wait.
// Reset: synchronous, active low; input count returns to 4, no result pending.
// ----------------------------------------------------------------------------
// NPN canonical form top level
// Exhaustive search over permutations, input negations and output polarity.
// ----------------------------------------------------------------------------
module npn_canonical_form_top import npncf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_truth_table,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_canonical_table,
    output logic        o_output_negated,
    output logic [3:0]  o_input_negation_mask,
    output logic [7:0]  o_permutation_code
);

    t_cmd c_cmd;
    t_sts c_sts;

    assign o_cfg_ready = 1'b1;

    npncf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (c_sts),
        .o_cmd      (c_cmd)
    );

    npncf_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_data            (i_cfg_data),
        .i_truth_table         (i_truth_table),
        .i_cmd                 (c_cmd),
        .o_sts                 (c_sts),
        .i_out_ready           (i_out_ready),
        .o_out_valid           (o_out_valid),
        .o_canonical_table     (o_canonical_table),
        .o_output_negated      (o_output_negated),
        .o_input_negation_mask (o_input_negation_mask),
        .o_permutation_code    (o_permutation_code)
    );

    // A taken beat starts a search, so no second beat is taken right after.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a search was starting");

    // The result register fills on the cycle after a publish.
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.publish |=> o_out_valid)
        else $error("published result not shown");

    // The final search step is followed by no further step.
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_cmd.step && c_sts.last) |=> !c_cmd.step)
        else $error("search ran past its last candidate");

    // Publishing never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.publish |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule
